>>> rtl/thread_ready_queue_scheduler_top_macros.svh
// Assertion macros used by the scheduler RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef THREAD_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define THREAD_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TRQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define TRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define TRQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TRQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/trq_pkg.sv
package trq_pkg;

  localparam logic [2:0] MODE_CHANGE  = 3'd0;
  localparam logic [2:0] MODE_AWAKE   = 3'd1;
  localparam logic [2:0] MODE_SLEEP   = 3'd2;
  localparam logic [2:0] MODE_YIELD   = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;

  localparam logic [1:0] TS_STOPPED   = 2'd0;
  localparam logic [1:0] TS_SUSPENDED = 2'd1;
  localparam logic [1:0] TS_RUNNING   = 2'd2;

  localparam logic [1:0] STAT_OK             = 2'd0;
  localparam logic [1:0] STAT_AWAKE_STOPPED  = 2'd1;
  localparam logic [1:0] STAT_NOT_HEAD       = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] thread_id;
    logic [1:0] req_state;
    logic       to_front;
  } event_t;

  typedef struct packed {
    logic       head_valid;
    logic [3:0] head_thread;
    logic [4:0] ready_count;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [1:0] run_state;
    logic       asleep;
  } thread_entry_t;

  typedef enum logic [2:0] {
    QOP_NONE,
    QOP_PUSH_BACK,
    QOP_PUSH_FRONT,
    QOP_REMOVE,
    QOP_ROTATE
  } qop_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_busy;
  } dp_status_t;

endpackage

>>> rtl/trq_queue.sv
module trq_queue #(
  parameter int NUM_THREADS = 16,
  localparam int THREAD_W = $clog2(NUM_THREADS),
  localparam int COUNT_W = $clog2(NUM_THREADS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                update,
  input  trq_pkg::qop_t       op,
  input  logic [THREAD_W-1:0] thread,
  output logic [THREAD_W-1:0] head,
  output logic [COUNT_W-1:0]  count,
  output logic [THREAD_W-1:0] head_next,
  output logic [COUNT_W-1:0]  count_next
);

  localparam logic [NUM_THREADS-1:0] ALL_ONES = '1;

  logic [THREAD_W-1:0]    cells      [NUM_THREADS];
  logic [THREAD_W-1:0]    cells_next [NUM_THREADS];
  logic [NUM_THREADS-1:0] match;
  logic [NUM_THREADS-1:0] shift_dn;
  logic [COUNT_W-1:0]     last_pos;
  logic                   found;
  logic                   full;

  // Every cell compares itself; a cell moves down when any cell at or below it matched.
  always_comb begin
    for (int i = 0; i < NUM_THREADS; i++) begin
      match[i] = (COUNT_W'(i) < count) && (cells[i] == thread);
    end
    for (int i = 0; i < NUM_THREADS; i++) begin
      shift_dn[i] = |(match & (ALL_ONES >> (NUM_THREADS - 1 - i)));
    end
  end

  assign found    = |match;
  assign full     = (count == COUNT_W'(NUM_THREADS));
  assign last_pos = count - 1'b1;

  always_comb begin
    count_next = count;
    for (int i = 0; i < NUM_THREADS; i++) begin
      cells_next[i] = cells[i];
    end
    case (op)
      trq_pkg::QOP_PUSH_BACK: begin
        if (!full) begin
          for (int i = 0; i < NUM_THREADS; i++) begin
            if (COUNT_W'(i) == count) begin
              cells_next[i] = thread;
            end
          end
          count_next = count + 1'b1;
        end
      end
      trq_pkg::QOP_PUSH_FRONT: begin
        if (!full) begin
          cells_next[0] = thread;
          for (int i = 1; i < NUM_THREADS; i++) begin
            cells_next[i] = cells[i-1];
          end
          count_next = count + 1'b1;
        end
      end
      trq_pkg::QOP_REMOVE: begin
        if (found) begin
          for (int i = 0; i < NUM_THREADS - 1; i++) begin
            if (shift_dn[i]) begin
              cells_next[i] = cells[i+1];
            end
          end
          count_next = count - 1'b1;
        end
      end
      trq_pkg::QOP_ROTATE: begin
        // The matching thread leaves and comes back at the tail; the length stays.
        if (found) begin
          for (int i = 0; i < NUM_THREADS - 1; i++) begin
            if (shift_dn[i]) begin
              cells_next[i] = cells[i+1];
            end
          end
          for (int i = 0; i < NUM_THREADS; i++) begin
            if (COUNT_W'(i) == last_pos) begin
              cells_next[i] = thread;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign head      = cells[0];
  assign head_next = cells_next[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (update) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      for (int i = 0; i < NUM_THREADS; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

endmodule

>>> rtl/trq_datapath.sv
module trq_datapath #(
  parameter int NUM_THREADS = 16,
  localparam int THREAD_W = $clog2(NUM_THREADS),
  localparam int COUNT_W = $clog2(NUM_THREADS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  trq_pkg::ctrl_cmd_t  cmd,
  input  trq_pkg::event_t     evt,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output trq_pkg::result_t    rsp,
  output trq_pkg::dp_status_t status
);

  trq_pkg::thread_entry_t table_mem [NUM_THREADS];
  logic [NUM_THREADS-1:0] written;

  trq_pkg::event_t        item;
  trq_pkg::thread_entry_t rd_entry;
  logic                   rd_written;
  trq_pkg::thread_entry_t cur;
  trq_pkg::thread_entry_t wr_entry;
  logic                   wr_en;
  logic [1:0]             stat;
  trq_pkg::qop_t          op;
  logic                   t_ok;

  logic [THREAD_W-1:0] rd_idx;
  logic [THREAD_W-1:0] idx;
  logic [THREAD_W-1:0] q_head;
  logic [THREAD_W-1:0] q_head_next;
  logic [COUNT_W-1:0]  q_count;
  logic [COUNT_W-1:0]  q_count_next;

  assign rd_idx = THREAD_W'(evt.thread_id);
  assign idx    = THREAD_W'(item.thread_id);
  assign t_ok   = 32'(item.thread_id) < NUM_THREADS;

  // The table entry is read while the transaction is taken, so it is ready in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item       <= evt;
      rd_entry   <= table_mem[rd_idx];
      rd_written <= written[rd_idx];
    end
  end

  // An entry never written since reset reads as stopped and awake.
  assign cur = rd_written ? rd_entry : '0;

  always_comb begin
    op       = trq_pkg::QOP_NONE;
    wr_en    = 1'b0;
    wr_entry = cur;
    stat     = trq_pkg::STAT_OK;
    if (t_ok) begin
      case (item.mode)
        trq_pkg::MODE_CHANGE: begin
          if ((item.req_state inside {trq_pkg::TS_STOPPED, trq_pkg::TS_SUSPENDED,
                                      trq_pkg::TS_RUNNING}) &&
              item.req_state != cur.run_state) begin
            wr_en              = 1'b1;
            wr_entry.run_state = item.req_state;
            case (cur.run_state)
              trq_pkg::TS_STOPPED: begin
                wr_entry.asleep = 1'b0;
                if (item.req_state == trq_pkg::TS_RUNNING) begin
                  op = trq_pkg::QOP_PUSH_BACK;
                end
              end
              trq_pkg::TS_RUNNING: begin
                if (!cur.asleep) begin
                  op = trq_pkg::QOP_REMOVE;
                end
              end
              default: begin
                if (item.req_state == trq_pkg::TS_RUNNING && !cur.asleep) begin
                  op = trq_pkg::QOP_PUSH_BACK;
                end
              end
            endcase
          end
        end
        trq_pkg::MODE_AWAKE: begin
          if (cur.run_state == trq_pkg::TS_STOPPED) begin
            stat = trq_pkg::STAT_AWAKE_STOPPED;
          end else if (cur.asleep) begin
            wr_en           = 1'b1;
            wr_entry.asleep = 1'b0;
            if (cur.run_state == trq_pkg::TS_RUNNING) begin
              op = item.to_front ? trq_pkg::QOP_PUSH_FRONT : trq_pkg::QOP_PUSH_BACK;
            end
          end
        end
        trq_pkg::MODE_SLEEP, trq_pkg::MODE_YIELD: begin
          if (q_count == '0 || q_head != idx) begin
            stat = trq_pkg::STAT_NOT_HEAD;
          end else if (item.mode == trq_pkg::MODE_SLEEP) begin
            op              = trq_pkg::QOP_REMOVE;
            wr_en           = 1'b1;
            wr_entry.asleep = 1'b1;
          end else begin
            op = trq_pkg::QOP_ROTATE;
          end
        end
        trq_pkg::MODE_RELEASE: begin
          if (cur.run_state != trq_pkg::TS_STOPPED) begin
            op = trq_pkg::QOP_REMOVE;
          end
          wr_en              = 1'b1;
          wr_entry.run_state = trq_pkg::TS_STOPPED;
          wr_entry.asleep    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      table_mem[idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (cmd.exec && wr_en) begin
      written[idx] <= 1'b1;
    end
  end

  trq_queue #(
    .NUM_THREADS(NUM_THREADS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .update     (cmd.exec),
    .op         (op),
    .thread     (idx),
    .head       (q_head),
    .count      (q_count),
    .head_next  (q_head_next),
    .count_next (q_count_next)
  );

  // The response reports the queue as it stands after this transaction.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.head_valid  <= (q_count_next != '0);
      rsp.head_thread <= (q_count_next != '0) ? 4'(q_head_next) : 4'd0;
      rsp.ready_count <= 5'(q_count_next);
      rsp.status      <= stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign status.rsp_busy = rsp_valid && !rsp_ready;

endmodule

>>> rtl/trq_ctrl.sv
module trq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  input  trq_pkg::dp_status_t dp,
  output trq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (evt_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold the update until the response register is free.
        if (!dp.rsp_busy) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign evt_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/thread_ready_queue_scheduler_top.sv
// Thread ready-queue scheduler. Each event transaction on evt (change state, awake,
// sleep, yield, release) updates a per-thread table of run state and sleep mark and an
// ordered ready queue, and produces exactly one response transaction on rsp giving the
// queue head, the queue length and a status code. The thread's table entry is read while
// the transaction is taken; the table and the queue are then updated and the response
// register loaded, and only after that is the next event taken, so a new event is not
// accepted while one is in progress. The update waits while an earlier response has not
// been taken. The thread table is cleared at reset at once through per-entry valid bits,
// so there is no clearing pass. Thread ids at or above NUM_THREADS leave all state alone
// and report status ok.
`include "thread_ready_queue_scheduler_top_macros.svh"

module thread_ready_queue_scheduler_top #(
  parameter int NUM_THREADS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  output logic             evt_ready,
  input  trq_pkg::event_t  evt,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output trq_pkg::result_t rsp
);

  trq_pkg::ctrl_cmd_t  cmd;
  trq_pkg::dp_status_t dp_status;

  trq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .dp        (dp_status),
    .cmd       (cmd)
  );

  trq_datapath #(
    .NUM_THREADS(NUM_THREADS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .evt       (evt),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .status    (dp_status)
  );

  `TRQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, evt_valid && evt_ready, !evt_ready)
  `TRQ_ASSERT_IMPL(a_head_matches_count, clk, rst, rsp_valid, rsp.head_valid == (rsp.ready_count != 5'd0))
  `TRQ_ASSERT_IMPL(a_status_code, clk, rst, rsp_valid, rsp.status == trq_pkg::STAT_OK || rsp.status == trq_pkg::STAT_AWAKE_STOPPED || rsp.status == trq_pkg::STAT_NOT_HEAD)

endmodule

>>> tb/sv/tb.sv
// Scoreboard with its own copy of the thread table and ready queue. Each accepted event
// transaction is applied here, and the response it should report is queued for comparison.
class sched_scoreboard #(parameter int NT = 16);
  logic [1:0]       run_st [NT];
  bit               asleep [NT];
  logic [3:0]       ready_q [$];
  trq_pkg::result_t expected_heads [$];
  int               errors;

  function new();
    foreach (run_st[i]) begin
      run_st[i] = trq_pkg::TS_STOPPED;
      asleep[i] = 1'b0;
    end
    errors = 0;
  endfunction

  function void enqueue(logic [3:0] t, bit front);
    // The queue only ever holds running threads that are awake, each once.
    if (ready_q.size() >= NT) return;
    if (front) ready_q.push_front(t);
    else ready_q.push_back(t);
  endfunction

  function void unqueue(logic [3:0] t);
    foreach (ready_q[i]) begin
      if (ready_q[i] == t) begin
        ready_q.delete(i);
        return;
      end
    end
  endfunction

  function int pending();
    return expected_heads.size();
  endfunction

  function void apply_event(trq_pkg::event_t e);
    logic [3:0] t;
    logic [1:0] cur;
    logic [1:0] stat;
    trq_pkg::result_t want;
    t = e.thread_id;
    cur = run_st[t];
    stat = trq_pkg::STAT_OK;
    case (e.mode)
      trq_pkg::MODE_CHANGE: begin
        if (e.req_state <= trq_pkg::TS_RUNNING && e.req_state != cur) begin
          if (cur == trq_pkg::TS_STOPPED) begin
            asleep[t] = 1'b0;
            if (e.req_state == trq_pkg::TS_RUNNING) enqueue(t, 1'b0);
          end else if (cur == trq_pkg::TS_RUNNING) begin
            // A sleeping thread is already out of the queue.
            if (!asleep[t]) unqueue(t);
          end else if (e.req_state == trq_pkg::TS_RUNNING && !asleep[t]) begin
            enqueue(t, 1'b0);
          end
          run_st[t] = e.req_state;
        end
      end
      trq_pkg::MODE_AWAKE: begin
        if (cur == trq_pkg::TS_STOPPED) begin
          stat = trq_pkg::STAT_AWAKE_STOPPED;
        end else if (asleep[t]) begin
          asleep[t] = 1'b0;
          if (cur == trq_pkg::TS_RUNNING) enqueue(t, e.to_front);
        end
      end
      trq_pkg::MODE_SLEEP, trq_pkg::MODE_YIELD: begin
        if (ready_q.size() == 0 || ready_q[0] != t) begin
          stat = trq_pkg::STAT_NOT_HEAD;
        end else begin
          void'(ready_q.pop_front());
          if (e.mode == trq_pkg::MODE_SLEEP) asleep[t] = 1'b1;
          else enqueue(t, 1'b0);
        end
      end
      trq_pkg::MODE_RELEASE: begin
        if (cur != trq_pkg::TS_STOPPED) unqueue(t);
        run_st[t] = trq_pkg::TS_STOPPED;
        asleep[t] = 1'b0;
      end
      default: ;
    endcase
    want.head_valid = (ready_q.size() != 0);
    want.head_thread = (ready_q.size() != 0) ? ready_q[0] : 4'd0;
    want.ready_count = 5'(ready_q.size());
    want.status = stat;
    expected_heads.push_back(want);
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(trq_pkg::result_t got);
    trq_pkg::result_t want;
    if (expected_heads.size() == 0) begin
      report_mismatch($sformatf("response transaction %h with none expected", got));
      return;
    end
    want = expected_heads.pop_front();
    if (got.head_valid !== want.head_valid)
      report_mismatch($sformatf("head_valid got %0d expected %0d",
                                got.head_valid, want.head_valid));
    if (got.head_thread !== want.head_thread)
      report_mismatch($sformatf("head_thread got %0d expected %0d",
                                got.head_thread, want.head_thread));
    if (got.ready_count !== want.ready_count)
      report_mismatch($sformatf("ready_count got %0d expected %0d",
                                got.ready_count, want.ready_count));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d expected %0d", got.status, want.status));
  endtask
endclass

module tb;
  localparam int NUM_THREADS = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 410;

  logic             clk;
  logic             rst = 1'b1;
  logic             evt_valid = 1'b0;
  logic             evt_ready;
  trq_pkg::event_t  evt = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  trq_pkg::result_t rsp;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  sched_scoreboard #(NUM_THREADS) sb;

  thread_ready_queue_scheduler_top #(
    .NUM_THREADS(NUM_THREADS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt      (evt),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && evt_valid && evt_ready) sb.apply_event(evt);
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic trq_pkg::event_t mk_event(logic [2:0] mode, logic [3:0] id,
                                               logic [1:0] ns, logic front);
    trq_pkg::event_t e;
    e.mode = mode;
    e.thread_id = id;
    e.req_state = ns;
    e.to_front = front;
    return e;
  endfunction

  // Mostly well-formed events: sleep and yield usually come from the head, and awake
  // usually targets a sleeping thread, so the queue sees real traffic.
  function automatic trq_pkg::event_t pick_event();
    trq_pkg::event_t e;
    int r;
    logic [3:0] sleepers [$];
    e.thread_id = 4'($urandom_range(NUM_THREADS - 1));
    e.req_state = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) :
                  ($urandom_range(1) ? trq_pkg::TS_RUNNING : 2'($urandom_range(1)));
    e.to_front = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 40) begin
      e.mode = trq_pkg::MODE_CHANGE;
    end else if (r < 55) begin
      e.mode = trq_pkg::MODE_AWAKE;
      foreach (sb.asleep[i])
        if (sb.asleep[i] && sb.run_st[i] != trq_pkg::TS_STOPPED) sleepers.push_back(4'(i));
      if (sleepers.size() != 0 && $urandom_range(9) < 7)
        e.thread_id = sleepers[$urandom_range(sleepers.size() - 1)];
    end else if (r < 85) begin
      e.mode = (r < 68) ? trq_pkg::MODE_SLEEP : trq_pkg::MODE_YIELD;
      if (sb.ready_q.size() != 0 && $urandom_range(9) < 8) e.thread_id = sb.ready_q[0];
    end else if (r < 94) begin
      e.mode = trq_pkg::MODE_RELEASE;
    end else begin
      e.mode = 3'($urandom_range(7, 5));
    end
    return e;
  endfunction

  // Called at a point where valid may be changed; returns at the accepting edge.
  task automatic send_event(input trq_pkg::event_t e, input bit pick);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      evt_valid <= 1'b0;
      @(negedge clk);
    end
    if (pick) e = pick_event();
    evt <= e;
    evt_valid <= 1'b1;
    do @(posedge clk); while (!evt_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    evt_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    send_event(mk_event(trq_pkg::MODE_YIELD, 4'd0, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_AWAKE, 4'd15, trq_pkg::TS_STOPPED, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd0, trq_pkg::TS_RUNNING, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, trq_pkg::TS_RUNNING, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, 2'd3, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, trq_pkg::TS_RUNNING, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_SLEEP, 4'd15, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_YIELD, 4'd0, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_SLEEP, 4'd15, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_AWAKE, 4'd15, trq_pkg::TS_STOPPED, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_SLEEP, 4'd15, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    // A sleeping thread moving between suspended and running stays out of the queue.
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, trq_pkg::TS_SUSPENDED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, trq_pkg::TS_RUNNING, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_AWAKE, 4'd15, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, trq_pkg::TS_SUSPENDED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd15, trq_pkg::TS_RUNNING, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_AWAKE, 4'd0, trq_pkg::TS_RUNNING, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_RELEASE, 4'd15, trq_pkg::TS_RUNNING, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_SLEEP, 4'd0, trq_pkg::TS_STOPPED, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd0, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_CHANGE, 4'd0, trq_pkg::TS_RUNNING, 1'b0), 1'b0);
    send_event(mk_event(3'd5, 4'd0, trq_pkg::TS_RUNNING, 1'b1), 1'b0);
    send_event(mk_event(3'd6, 4'd15, trq_pkg::TS_SUSPENDED, 1'b0), 1'b0);
    send_event(mk_event(3'd7, 4'd0, 2'd3, 1'b1), 1'b0);
    send_event(mk_event(trq_pkg::MODE_RELEASE, 4'd0, trq_pkg::TS_STOPPED, 1'b0), 1'b0);
    send_event(mk_event(trq_pkg::MODE_RELEASE, 4'd0, trq_pkg::TS_STOPPED, 1'b1), 1'b0);
  endtask

  task automatic run_phase(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (PHASE_ITEMS) send_event('0, 1'b1);
    // The sender holds off here until every response transaction is back.
    drain();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    drain();
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(29, 29);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/trq_pkg.sv
rtl/trq_queue.sv
rtl/trq_datapath.sv
rtl/trq_ctrl.sv
rtl/thread_ready_queue_scheduler_top.sv
tb/sv/tb.sv
